@@ hw/rtl/dlp_rsp_pkg.sv @@
// shared types and codes for the desktop-link response argument parser
// no dependencies; used by every module of the block
`default_nettype none

package dlp_rsp_pkg;

  // parser phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_ARGH = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  // argument header kinds
  localparam logic [1:0] KIND_TINY  = 2'd0;
  localparam logic [1:0] KIND_SMALL = 2'd2;
  localparam logic [1:0] KIND_LONG  = 2'd3;

  // argument header lengths in bytes
  localparam logic [2:0] HDR_LEN_TINY  = 3'd2;
  localparam logic [2:0] HDR_LEN_SMALL = 3'd4;
  localparam logic [2:0] HDR_LEN_LONG  = 3'd6;

  // header byte positions
  localparam logic [2:0] HB_ID     = 3'd0;
  localparam logic [2:0] HB_ARGC   = 3'd1;
  localparam logic [2:0] HB_ERR_HI = 3'd2;

  // byte roles
  localparam logic [2:0] ROLE_ARG_HDR  = 3'd4;
  localparam logic [2:0] ROLE_ARG_DATA = 3'd5;
  localparam logic [2:0] ROLE_IGNORED  = 3'd6;

  // status codes
  localparam logic [2:0] ST_BUSY      = 3'd0;
  localparam logic [2:0] ST_OK        = 3'd1;
  localparam logic [2:0] ST_NOT_RESP  = 3'd2;
  localparam logic [2:0] ST_BAD_ID    = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;

  // bit masks
  localparam logic [7:0] RESP_BIT  = 8'h80;
  localparam logic [7:0] KIND_MASK = 8'hc0;
  localparam logic [7:0] KIND_LONG_BITS  = 8'hc0;
  localparam logic [7:0] KIND_SMALL_BITS = 8'h80;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_byte;
    logic       last_byte;
    logic [6:0] expected_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [7:0]  resp_argc;
    logic [15:0] resp_error;
    logic [7:0]  arg_index;
    logic [13:0] arg_ident;
    logic [31:0] arg_length;
    logic        arg_header_done;
    logic [31:0] data_offset;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic        message_done;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/dlp_rsp_in_stage.sv @@
// input register of the response parser: holds one accepted beat
// depends on dlp_rsp_pkg
`default_nettype none

module dlp_rsp_in_stage (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire dlp_rsp_pkg::in_item_t in_item,
  input  wire logic                take,
  output logic                     item_valid,
  output dlp_rsp_pkg::in_item_t    item
);

  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/dlp_rsp_core.sv @@
// parser state and single-pass byte decode of the response message
// depends on dlp_rsp_pkg
`default_nettype none

module dlp_rsp_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire dlp_rsp_pkg::in_item_t item,
  output dlp_rsp_pkg::result_t       result
);

  logic [1:0]  phase, phase_next;
  logic [2:0]  hbc, hbc_next;
  logic [1:0]  arg_kind, arg_kind_next;
  logic [6:0]  saved_id, saved_id_next;
  logic [7:0]  argc_seen, argc_seen_next;
  logic [7:0]  current_arg, current_arg_next;
  logic [15:0] error_seen, error_seen_next;
  logic [13:0] cur_ident, cur_ident_next;
  logic [31:0] cur_length, cur_length_next;
  logic [31:0] bytes_left, bytes_left_next;

  always_comb begin
    logic [7:0]  b;
    logic        active;
    logic        complete;
    logic        end_arg;
    logic [2:0]  hdr_end;
    logic [7:0]  arg_inc;

    b        = item.in_byte;
    complete = 1'b0;
    end_arg  = 1'b0;
    hdr_end  = dlp_rsp_pkg::HDR_LEN_TINY;

    if (item.first_byte) begin
      phase_next       = dlp_rsp_pkg::PH_HEAD;
      hbc_next         = '0;
      arg_kind_next    = dlp_rsp_pkg::KIND_TINY;
      saved_id_next    = item.expected_id;
      argc_seen_next   = '0;
      current_arg_next = '0;
      error_seen_next  = '0;
      cur_ident_next   = '0;
      cur_length_next  = '0;
      bytes_left_next  = '0;
    end else begin
      phase_next       = phase;
      hbc_next         = hbc;
      arg_kind_next    = arg_kind;
      saved_id_next    = saved_id;
      argc_seen_next   = argc_seen;
      current_arg_next = current_arg;
      error_seen_next  = error_seen;
      cur_ident_next   = cur_ident;
      cur_length_next  = cur_length;
      bytes_left_next  = bytes_left;
    end

    result           = '0;
    result.byte_role = dlp_rsp_pkg::ROLE_IGNORED;
    result.status    = dlp_rsp_pkg::ST_BUSY;
    result.arg_index = current_arg_next;
    active           = (phase_next != dlp_rsp_pkg::PH_IDLE);
    arg_inc          = current_arg_next + 8'd1;

    case (phase_next)
      dlp_rsp_pkg::PH_HEAD: begin
        result.byte_role = hbc_next;
        if (hbc_next == dlp_rsp_pkg::HB_ID) begin
          if ((b & dlp_rsp_pkg::RESP_BIT) == 8'd0) begin
            result.status       = dlp_rsp_pkg::ST_NOT_RESP;
            result.message_done = 1'b1;
            phase_next          = dlp_rsp_pkg::PH_IDLE;
            active              = 1'b0;
          end else if (b[6:0] != saved_id_next) begin
            result.status       = dlp_rsp_pkg::ST_BAD_ID;
            result.message_done = 1'b1;
            phase_next          = dlp_rsp_pkg::PH_IDLE;
            active              = 1'b0;
          end
          hbc_next = hbc_next + 3'd1;
        end else if (hbc_next == dlp_rsp_pkg::HB_ARGC) begin
          argc_seen_next = b;
          hbc_next       = hbc_next + 3'd1;
        end else if (hbc_next == dlp_rsp_pkg::HB_ERR_HI) begin
          error_seen_next = {b, 8'd0};
          hbc_next        = hbc_next + 3'd1;
        end else begin
          error_seen_next = {error_seen_next[15:8], b};
          if (argc_seen_next == 8'd0) begin
            complete = 1'b1;
            hbc_next = hbc_next + 3'd1;
          end else begin
            phase_next = dlp_rsp_pkg::PH_ARGH;
            hbc_next   = '0;
          end
        end
      end
      dlp_rsp_pkg::PH_ARGH: begin
        result.byte_role = dlp_rsp_pkg::ROLE_ARG_HDR;
        if (hbc_next == 3'd0) begin
          if ((b & dlp_rsp_pkg::KIND_MASK) == dlp_rsp_pkg::KIND_LONG_BITS) begin
            arg_kind_next = dlp_rsp_pkg::KIND_LONG;
          end else if ((b & dlp_rsp_pkg::KIND_MASK) == dlp_rsp_pkg::KIND_SMALL_BITS) begin
            arg_kind_next = dlp_rsp_pkg::KIND_SMALL;
          end else begin
            arg_kind_next = dlp_rsp_pkg::KIND_TINY;
          end
          cur_ident_next  = {8'd0, b[5:0]};
          cur_length_next = '0;
        end else if (arg_kind_next == dlp_rsp_pkg::KIND_LONG) begin
          if (hbc_next == 3'd1) begin
            cur_ident_next = {cur_ident_next[5:0], b};
          end else begin
            cur_length_next = {cur_length_next[23:0], b};
          end
        end else if (arg_kind_next == dlp_rsp_pkg::KIND_SMALL) begin
          if (hbc_next >= 3'd2) begin
            cur_length_next = {cur_length_next[23:0], b};
          end
        end else begin
          cur_length_next = {24'd0, b};
        end
        if (arg_kind_next == dlp_rsp_pkg::KIND_LONG) begin
          hdr_end = dlp_rsp_pkg::HDR_LEN_LONG;
        end else if (arg_kind_next == dlp_rsp_pkg::KIND_SMALL) begin
          hdr_end = dlp_rsp_pkg::HDR_LEN_SMALL;
        end
        hbc_next = hbc_next + 3'd1;
        if (hbc_next >= hdr_end) begin
          result.arg_header_done = 1'b1;
          if (cur_length_next == 32'd0) begin
            end_arg = 1'b1;
          end else begin
            bytes_left_next = cur_length_next;
            phase_next      = dlp_rsp_pkg::PH_DATA;
          end
        end
      end
      dlp_rsp_pkg::PH_DATA: begin
        result.byte_role   = dlp_rsp_pkg::ROLE_ARG_DATA;
        result.data_byte   = b;
        result.data_offset = cur_length_next - bytes_left_next;
        bytes_left_next    = bytes_left_next - 32'd1;
        if (bytes_left_next == 32'd0) begin
          end_arg = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // advance past a finished argument
    if (end_arg) begin
      current_arg_next = arg_inc;
      if (arg_inc == argc_seen_next) begin
        complete = 1'b1;
      end else begin
        phase_next = dlp_rsp_pkg::PH_ARGH;
        hbc_next   = '0;
      end
    end

    if (complete) begin
      result.status       = item.last_byte ? dlp_rsp_pkg::ST_OK : dlp_rsp_pkg::ST_TRUNCATED;
      result.message_done = 1'b1;
      phase_next          = dlp_rsp_pkg::PH_IDLE;
    end else if (active && item.last_byte) begin
      result.status       = dlp_rsp_pkg::ST_TRUNCATED;
      result.message_done = 1'b1;
      phase_next          = dlp_rsp_pkg::PH_IDLE;
    end

    result.resp_argc  = argc_seen_next;
    result.resp_error = error_seen_next;
    result.arg_ident  = cur_ident_next;
    result.arg_length = cur_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= dlp_rsp_pkg::PH_HEAD;
      hbc         <= '0;
      arg_kind    <= dlp_rsp_pkg::KIND_TINY;
      saved_id    <= '0;
      argc_seen   <= '0;
      current_arg <= '0;
      error_seen  <= '0;
      cur_ident   <= '0;
      cur_length  <= '0;
      bytes_left  <= '0;
    end else if (step) begin
      phase       <= phase_next;
      hbc         <= hbc_next;
      arg_kind    <= arg_kind_next;
      saved_id    <= saved_id_next;
      argc_seen   <= argc_seen_next;
      current_arg <= current_arg_next;
      error_seen  <= error_seen_next;
      cur_ident   <= cur_ident_next;
      cur_length  <= cur_length_next;
      bytes_left  <= bytes_left_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/dlp_rsp_out_stage.sv @@
// result register of the response parser: holds one beat until taken
// depends on dlp_rsp_pkg
`default_nettype none

module dlp_rsp_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire dlp_rsp_pkg::result_t load_result,
  output logic                      room,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output dlp_rsp_pkg::result_t      out_result
);

  assign room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load) begin
      out_result <= load_result;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/dlp_response_arg_parser.sv @@
// top level of the desktop-link response argument parser
// depends on dlp_rsp_pkg, dlp_rsp_in_stage, dlp_rsp_core and dlp_rsp_out_stage
//
// One response byte comes in per beat, with tuser marking the first byte of a
// message and tlast its final byte; every byte gives exactly one result beat,
// which tags the byte with its role (header field, argument header, argument
// data) and carries the decoded argument count, error code, argument id and
// size, the data offset and, on the last result of a message, the status. The
// block takes one byte every clock cycle while results are taken; a byte passes
// through an input register, the decode and state update in one pass, and a
// result register. A result beat that waits on the output holds the byte
// behind it in the input register. There is no memory and no start-up pass.
`default_nettype none

module dlp_response_arg_parser (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [15:0]  s_axis_tdata,  // in_byte, expected_id, zero pad
  input  wire logic         s_axis_tlast,  // last_byte
  input  wire logic [0:0]   s_axis_tuser,  // first_byte
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // resp_argc, resp_error, arg_index, arg_ident, arg_length, arg_header_done,
  // data_offset, data_byte, status, zero pad
  output logic [127:0]      m_axis_tdata,
  output logic              m_axis_tlast,  // message_done
  output logic [2:0]        m_axis_tuser   // byte_role
);

  dlp_rsp_pkg::in_item_t s_item;
  dlp_rsp_pkg::in_item_t item;
  dlp_rsp_pkg::result_t  step_result;
  dlp_rsp_pkg::result_t  out_result;
  logic                  item_valid;
  logic                  room;
  logic                  take;

  assign s_item.in_byte     = s_axis_tdata[7:0];
  assign s_item.expected_id = s_axis_tdata[14:8];
  assign s_item.first_byte  = s_axis_tuser[0];
  assign s_item.last_byte   = s_axis_tlast;

  assign take = item_valid && room;

  dlp_rsp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (s_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  dlp_rsp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (take),
    .item   (item),
    .result (step_result)
  );

  dlp_rsp_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .load        (take),
    .load_result (step_result),
    .room        (room),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_result  (out_result)
  );

  assign m_axis_tdata = {6'd0,
                         out_result.status,
                         out_result.data_byte,
                         out_result.data_offset,
                         out_result.arg_header_done,
                         out_result.arg_length,
                         out_result.arg_ident,
                         out_result.arg_index,
                         out_result.resp_error,
                         out_result.resp_argc};
  assign m_axis_tlast = out_result.message_done;
  assign m_axis_tuser = out_result.byte_role;

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// testbench for dlp_response_arg_parser: a directed table, then random response messages
// every result beat is checked: against the row's expected result where the directed table gives one,
// else against a byte-level parser model kept in this file; depends on dlp_rsp_pkg and the parser rtl

module tb_top;

  localparam logic [2:0]  HB_ERR_LO     = 3'd3;
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned RANDOM_BEATS  = 900;
  localparam int unsigned MAX_MSG_BYTES = 64;
  localparam int unsigned TAIL_CYCLES   = 40;

  typedef struct {
    dlp_rsp_pkg::in_item_t item;
    bit                    typed;
    dlp_rsp_pkg::result_t  res;
  } stim_row_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata;   // in_byte, expected_id, zero pad
  logic         s_axis_tlast;   // last_byte
  logic [0:0]   s_axis_tuser;   // first_byte
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // resp_argc, resp_error, arg_index, arg_ident, arg_length, arg_header_done,
  // data_offset, data_byte, status, zero pad
  logic [127:0] m_axis_tdata;
  logic         m_axis_tlast;   // message_done
  logic [2:0]   m_axis_tuser;   // byte_role

  // mirrored parser state
  logic [1:0]  ps_phase;
  logic [2:0]  ps_hdr_cnt;
  logic [1:0]  ps_kind;
  logic [6:0]  ps_want_id;
  logic [7:0]  ps_argc;
  logic [7:0]  ps_arg;
  logic [15:0] ps_error;
  logic [13:0] ps_ident;
  logic [31:0] ps_length;
  logic [31:0] ps_left;

  dlp_rsp_pkg::result_t  pending_results[$];
  stim_row_t             stim_rows[$];
  dlp_rsp_pkg::in_item_t msg_bytes[$];
  int unsigned mismatch_count;
  int unsigned idle_cycles = 0;
  int unsigned in_beats, out_beats, in_mode, out_mode, counted_beats;

  dlp_response_arg_parser u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  function automatic void open_message(logic [6:0] eid);
    ps_phase   = dlp_rsp_pkg::PH_HEAD;
    ps_hdr_cnt = 3'd0;
    ps_kind    = dlp_rsp_pkg::KIND_TINY;
    ps_want_id = eid;
    ps_argc    = 8'd0;
    ps_arg     = 8'd0;
    ps_error   = 16'd0;
    ps_ident   = 14'd0;
    ps_length  = 32'd0;
    ps_left    = 32'd0;
  endfunction

  function automatic bit close_argument();
    ps_arg = ps_arg + 8'd1;
    if (ps_arg == ps_argc) return 1'b1;
    ps_phase   = dlp_rsp_pkg::PH_ARGH;
    ps_hdr_cnt = 3'd0;
    return 1'b0;
  endfunction

  function automatic dlp_rsp_pkg::result_t parse_byte(dlp_rsp_pkg::in_item_t it);
    dlp_rsp_pkg::result_t r;
    logic [2:0] hdr_end;
    logic       complete;
    logic       active;
    r = '0;
    r.byte_role = dlp_rsp_pkg::ROLE_IGNORED;
    complete = 1'b0;
    if (it.first_byte) open_message(it.expected_id);
    r.arg_index = ps_arg;
    active = (ps_phase != dlp_rsp_pkg::PH_IDLE);
    case (ps_phase)
      dlp_rsp_pkg::PH_HEAD: begin
        r.byte_role = ps_hdr_cnt;
        if (ps_hdr_cnt == dlp_rsp_pkg::HB_ID) begin
          // a cleared response bit wins over an id mismatch
          if ((it.in_byte & dlp_rsp_pkg::RESP_BIT) == 8'h00) begin
            r.status = dlp_rsp_pkg::ST_NOT_RESP;
          end else if (it.in_byte[6:0] != ps_want_id) begin
            r.status = dlp_rsp_pkg::ST_BAD_ID;
          end
          if (r.status != dlp_rsp_pkg::ST_BUSY) begin
            r.message_done = 1'b1;
            ps_phase = dlp_rsp_pkg::PH_IDLE;
            active = 1'b0;
          end
        end else if (ps_hdr_cnt == dlp_rsp_pkg::HB_ARGC) begin
          ps_argc = it.in_byte;
        end else if (ps_hdr_cnt == dlp_rsp_pkg::HB_ERR_HI) begin
          ps_error = {it.in_byte, 8'h00};
        end else begin
          ps_error[7:0] = it.in_byte;
          if (ps_argc == 8'd0) complete = 1'b1;
          else ps_phase = dlp_rsp_pkg::PH_ARGH;
        end
        ps_hdr_cnt = (ps_phase == dlp_rsp_pkg::PH_ARGH) ? 3'd0 : ps_hdr_cnt + 3'd1;
      end
      dlp_rsp_pkg::PH_ARGH: begin
        r.byte_role = dlp_rsp_pkg::ROLE_ARG_HDR;
        if (ps_hdr_cnt == 3'd0) begin
          if ((it.in_byte & dlp_rsp_pkg::KIND_MASK) == dlp_rsp_pkg::KIND_LONG_BITS)
            ps_kind = dlp_rsp_pkg::KIND_LONG;
          else if ((it.in_byte & dlp_rsp_pkg::KIND_MASK) == dlp_rsp_pkg::KIND_SMALL_BITS)
            ps_kind = dlp_rsp_pkg::KIND_SMALL;
          else
            ps_kind = dlp_rsp_pkg::KIND_TINY;
          ps_ident  = {8'h00, it.in_byte[5:0]};
          ps_length = 32'd0;
        end else if (ps_kind == dlp_rsp_pkg::KIND_LONG) begin
          if (ps_hdr_cnt == 3'd1) ps_ident = 14'({ps_ident, it.in_byte});
          else ps_length = {ps_length[23:0], it.in_byte};
        end else if (ps_kind == dlp_rsp_pkg::KIND_SMALL) begin
          if (ps_hdr_cnt >= 3'd2) ps_length = {ps_length[23:0], it.in_byte};
        end else begin
          ps_length = {24'h0, it.in_byte};
        end
        hdr_end = (ps_kind == dlp_rsp_pkg::KIND_LONG) ? dlp_rsp_pkg::HDR_LEN_LONG :
                  (ps_kind == dlp_rsp_pkg::KIND_SMALL) ? dlp_rsp_pkg::HDR_LEN_SMALL :
                  dlp_rsp_pkg::HDR_LEN_TINY;
        ps_hdr_cnt = ps_hdr_cnt + 3'd1;
        if (ps_hdr_cnt >= hdr_end) begin
          r.arg_header_done = 1'b1;
          if (ps_length == 32'd0) begin
            complete = close_argument();
          end else begin
            ps_left  = ps_length;
            ps_phase = dlp_rsp_pkg::PH_DATA;
          end
        end
      end
      dlp_rsp_pkg::PH_DATA: begin
        r.byte_role   = dlp_rsp_pkg::ROLE_ARG_DATA;
        r.data_byte   = it.in_byte;
        r.data_offset = ps_length - ps_left;
        ps_left = ps_left - 32'd1;
        if (ps_left == 32'd0) complete = close_argument();
      end
      default: ;
    endcase
    if (complete) begin
      r.status = it.last_byte ? dlp_rsp_pkg::ST_OK : dlp_rsp_pkg::ST_TRUNCATED;
      r.message_done = 1'b1;
      ps_phase = dlp_rsp_pkg::PH_IDLE;
    end else if (active && it.last_byte) begin
      r.status = dlp_rsp_pkg::ST_TRUNCATED;
      r.message_done = 1'b1;
      ps_phase = dlp_rsp_pkg::PH_IDLE;
    end
    r.resp_argc  = ps_argc;
    r.resp_error = ps_error;
    r.arg_ident  = ps_ident;
    r.arg_length = ps_length;
    return r;
  endfunction

  function automatic dlp_rsp_pkg::result_t unpack_result(logic [127:0] d, logic done,
                                                         logic [2:0] role);
    dlp_rsp_pkg::result_t r;
    r.byte_role       = role;
    r.resp_argc       = d[7:0];
    r.resp_error      = d[23:8];
    r.arg_index       = d[31:24];
    r.arg_ident       = d[45:32];
    r.arg_length      = d[77:46];
    r.arg_header_done = d[78];
    r.data_offset     = d[110:79];
    r.data_byte       = d[118:111];
    r.status          = d[121:119];
    r.message_done    = done;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void compare_result(dlp_rsp_pkg::result_t want,
                                         dlp_rsp_pkg::result_t got);
    check_field("byte_role", 32'(want.byte_role), 32'(got.byte_role));
    check_field("resp_argc", 32'(want.resp_argc), 32'(got.resp_argc));
    check_field("resp_error", 32'(want.resp_error), 32'(got.resp_error));
    check_field("arg_index", 32'(want.arg_index), 32'(got.arg_index));
    check_field("arg_ident", 32'(want.arg_ident), 32'(got.arg_ident));
    check_field("arg_length", want.arg_length, got.arg_length);
    check_field("arg_header_done", 32'(want.arg_header_done), 32'(got.arg_header_done));
    check_field("data_offset", want.data_offset, got.data_offset);
    check_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
    check_field("status", 32'(want.status), 32'(got.status));
    check_field("message_done", 32'(want.message_done), 32'(got.message_done));
  endfunction

  function automatic int unsigned draw_gap(int unsigned mode);
    case (mode)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  function automatic dlp_rsp_pkg::in_item_t mk_in(logic [7:0] b, bit first, bit last,
                                                  logic [6:0] eid);
    dlp_rsp_pkg::in_item_t it;
    it.in_byte     = b;
    it.first_byte  = first;
    it.last_byte   = last;
    it.expected_id = eid;
    return it;
  endfunction

  function automatic dlp_rsp_pkg::result_t mk_res(logic [2:0] role, logic [7:0] argc,
                                                  logic [15:0] err, logic [2:0] st,
                                                  logic done);
    dlp_rsp_pkg::result_t r;
    r = '0;
    r.byte_role    = role;
    r.resp_argc    = argc;
    r.resp_error   = err;
    r.status       = st;
    r.message_done = done;
    return r;
  endfunction

  function automatic void add_row(logic [7:0] b, bit first, bit last, logic [6:0] eid);
    stim_row_t row;
    row.item  = mk_in(b, first, last, eid);
    row.typed = 1'b0;
    row.res   = '0;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_checked(logic [7:0] b, bit first, bit last, logic [6:0] eid,
                                      dlp_rsp_pkg::result_t res);
    stim_row_t row;
    row.item  = mk_in(b, first, last, eid);
    row.typed = 1'b1;
    row.res   = res;
    stim_rows.push_back(row);
  endfunction

  function automatic void put_byte(logic [7:0] b, bit last);
    msg_bytes.push_back(mk_in(b, 1'b0, last, 7'($urandom)));
  endfunction

  function automatic logic [31:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(0, 4);
    if (r < 18) return $urandom_range(5, 16);
    return $urandom;
  endfunction

  task automatic build_message();
    int unsigned flavour, n_args, a, i, cut;
    logic [1:0]  kind;
    logic [31:0] arg_size;
    logic [6:0]  rid;
    logic [7:0]  id_byte;
    bit          tail_last;
    dlp_rsp_pkg::in_item_t ed;
    msg_bytes.delete();
    flavour = $urandom_range(0, 99);
    rid = 7'($urandom);
    if (flavour < 5) begin
      // stray bytes with no first byte
      repeat ($urandom_range(1, 3)) put_byte(8'($urandom), 1'($urandom));
      return;
    end
    id_byte = {1'b1, rid};
    if (flavour < 11) begin
      if ($urandom_range(0, 1) == 1) id_byte[7] = 1'b0;
      else id_byte[6:0] = rid ^ 7'($urandom_range(1, 127));
    end
    put_byte(id_byte, 1'b0);
    n_args = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 255) : $urandom_range(0, 4);
    put_byte(8'(n_args), 1'b0);
    put_byte(8'($urandom), 1'b0);
    put_byte(8'($urandom), 1'b0);
    for (a = 0; a < n_args && msg_bytes.size() < MAX_MSG_BYTES; a++) begin
      kind = 2'($urandom);
      arg_size = pick_size();
      case (kind)
        2'b11: begin
          put_byte({kind, 6'($urandom)}, 1'b0);
          put_byte(8'($urandom), 1'b0);
          put_byte(arg_size[31:24], 1'b0);
          put_byte(arg_size[23:16], 1'b0);
          put_byte(arg_size[15:8], 1'b0);
          put_byte(arg_size[7:0], 1'b0);
        end
        2'b10: begin
          arg_size = arg_size & 32'hffff;
          put_byte({kind, 6'($urandom)}, 1'b0);
          put_byte(8'($urandom), 1'b0);
          put_byte(arg_size[15:8], 1'b0);
          put_byte(arg_size[7:0], 1'b0);
        end
        default: begin
          arg_size = arg_size & 32'hff;
          put_byte({kind, 6'($urandom)}, 1'b0);
          put_byte(arg_size[7:0], 1'b0);
        end
      endcase
      for (i = 0; i < arg_size && msg_bytes.size() < MAX_MSG_BYTES; i++)
        put_byte(8'($urandom), 1'b0);
    end
    tail_last = 1'b1;
    if (flavour < 11) begin
      // rejected id, keep a random tail of ignored bytes
      cut = $urandom_range(1, msg_bytes.size());
      tail_last = 1'($urandom);
    end else if (flavour < 19) begin
      // early end
      cut = $urandom_range(1, msg_bytes.size() - 1);
    end else if (flavour < 25) begin
      // overrun past the completing byte
      repeat ($urandom_range(1, 3)) put_byte(8'($urandom), 1'b0);
      cut = msg_bytes.size();
      tail_last = 1'($urandom);
    end else if (flavour < 30) begin
      // abandoned by the next first byte
      cut = $urandom_range(1, msg_bytes.size());
      tail_last = 1'b0;
    end else begin
      cut = msg_bytes.size();
    end
    while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
    ed = msg_bytes[msg_bytes.size() - 1];
    ed.last_byte = tail_last;
    msg_bytes[msg_bytes.size() - 1] = ed;
    if (flavour < 30 || flavour >= 33) begin
      ed = msg_bytes[0];
      ed.first_byte  = 1'b1;
      ed.expected_id = rid;
      msg_bytes[0] = ed;
    end
  endtask

  // entered and left at a falling edge
  task automatic drive_beat(input dlp_rsp_pkg::in_item_t it, input bit typed,
                            input dlp_rsp_pkg::result_t typed_res,
                            output logic [2:0] role);
    int unsigned gap;
    dlp_rsp_pkg::result_t pred;
    if (in_beats % 40 == 0) in_mode = $urandom_range(0, 2);
    in_beats++;
    gap = draw_gap(in_mode);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, it.expected_id, it.in_byte};
    s_axis_tlast  <= it.last_byte;
    s_axis_tuser  <= it.first_byte;
    do @(posedge clk); while (!s_axis_tready);
    pred = parse_byte(it);
    pending_results.push_back(typed ? typed_res : pred);
    role = pred.byte_role;
    @(negedge clk);
  endtask

  function automatic void build_directed();
    // stream opening without a first byte after reset, zero arguments, extreme error code
    add_checked(8'h80, 1'b0, 1'b0, 7'h00,
                mk_res(dlp_rsp_pkg::HB_ID, 8'd0, 16'h0000, dlp_rsp_pkg::ST_BUSY, 1'b0));
    add_checked(8'h00, 1'b0, 1'b0, 7'h7f,
                mk_res(dlp_rsp_pkg::HB_ARGC, 8'd0, 16'h0000, dlp_rsp_pkg::ST_BUSY, 1'b0));
    add_checked(8'hff, 1'b0, 1'b0, 7'h00,
                mk_res(dlp_rsp_pkg::HB_ERR_HI, 8'd0, 16'hff00, dlp_rsp_pkg::ST_BUSY, 1'b0));
    add_checked(8'hff, 1'b0, 1'b1, 7'h00,
                mk_res(HB_ERR_LO, 8'd0, 16'hffff, dlp_rsp_pkg::ST_OK, 1'b1));
    // not a response although the id bits match, then a bad id
    add_checked(8'h7f, 1'b1, 1'b0, 7'h7f,
                mk_res(dlp_rsp_pkg::HB_ID, 8'd0, 16'h0000, dlp_rsp_pkg::ST_NOT_RESP, 1'b1));
    add_checked(8'hff, 1'b1, 1'b0, 7'h00,
                mk_res(dlp_rsp_pkg::HB_ID, 8'd0, 16'h0000, dlp_rsp_pkg::ST_BAD_ID, 1'b1));
    // idle byte, its last flag ignored
    add_checked(8'h00, 1'b0, 1'b1, 7'h00,
                mk_res(dlp_rsp_pkg::ROLE_IGNORED, 8'd0, 16'h0000, dlp_rsp_pkg::ST_BUSY, 1'b0));
    // abandoned message, restarted
    add_row(8'h81, 1'b1, 1'b0, 7'h01);
    add_row(8'h02, 1'b0, 1'b0, 7'h00);
    add_row(8'hff, 1'b1, 1'b0, 7'h7f);
    add_row(8'h03, 1'b0, 1'b0, 7'h00);
    add_row(8'h00, 1'b0, 1'b0, 7'h00);
    add_row(8'hff, 1'b0, 1'b0, 7'h00);
    // tiny header with kind bits 01, one data byte
    add_row(8'h7f, 1'b0, 1'b0, 7'h00);
    add_row(8'h01, 1'b0, 1'b0, 7'h00);
    add_row(8'hff, 1'b0, 1'b0, 7'h00);
    // small header, zero size
    add_row(8'hbf, 1'b0, 1'b0, 7'h00);
    add_row(8'hff, 1'b0, 1'b0, 7'h00);
    add_row(8'h00, 1'b0, 1'b0, 7'h00);
    add_row(8'h00, 1'b0, 1'b0, 7'h00);
    // long header with the widest id, one data byte, no last flag so it overruns
    add_row(8'hff, 1'b0, 1'b0, 7'h00);
    add_row(8'hff, 1'b0, 1'b0, 7'h00);
    add_row(8'h00, 1'b0, 1'b0, 7'h00);
    add_row(8'h00, 1'b0, 1'b0, 7'h00);
    add_row(8'h00, 1'b0, 1'b0, 7'h00);
    add_row(8'h01, 1'b0, 1'b0, 7'h00);
    add_row(8'h00, 1'b0, 1'b0, 7'h00);
    // message ending on its id byte
    add_checked(8'h80, 1'b1, 1'b1, 7'h00,
                mk_res(dlp_rsp_pkg::HB_ID, 8'd0, 16'h0000, dlp_rsp_pkg::ST_TRUNCATED, 1'b1));
  endfunction

  initial begin
    logic [2:0] role;
    clk = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    mismatch_count = 0;
    in_beats = 0;
    in_mode = 0;
    counted_beats = 0;
    open_message(7'd0);
    build_directed();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    foreach (stim_rows[i])
      drive_beat(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].res, role);
    while (counted_beats < RANDOM_BEATS) begin
      build_message();
      foreach (msg_bytes[k]) begin
        drive_beat(msg_bytes[k], 1'b0, '0, role);
        if (role != dlp_rsp_pkg::ROLE_IGNORED) counted_beats++;
      end
    end
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // result side
  initial begin
    int unsigned gap;
    dlp_rsp_pkg::result_t got;
    out_beats = 0;
    out_mode = 0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (out_beats % 40 == 0) out_mode = $urandom_range(0, 2);
      gap = draw_gap(out_mode);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      out_beats++;
      got = unpack_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      if (pending_results.size() == 0) begin
        $display("%0t: result beat expected none got %h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        compare_result(pending_results.pop_front(), got);
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ sim.f @@
hw/rtl/dlp_rsp_pkg.sv
hw/rtl/dlp_rsp_in_stage.sv
hw/rtl/dlp_rsp_core.sv
hw/rtl/dlp_rsp_out_stage.sv
hw/rtl/dlp_response_arg_parser.sv
bench/tb_top.sv
